### hdl/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg
// shared constants, types and mode codes of the prefix code bit packer
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int BYTE_BITS    = 8;
    localparam int VALUE_BITS   = 32;

    // longest code the table can hold
    localparam int LEN_LIMIT = (MAX_CODE_LEN < VALUE_BITS) ? MAX_CODE_LEN : VALUE_BITS;

    localparam int SYM_W   = 8;
    localparam int LEN_W   = 6;
    localparam int MODE_W  = 2;
    localparam int PEND_W  = 7;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = PEND_W + VALUE_BITS;
    localparam int TOTAL_W = $clog2(ACC_W + 1);
    localparam int LEFT_W  = $clog2(ACC_W / BYTE_BITS + 1);
    localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // item leaving the table lookup stage
    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic              hit;
        t_entry            entry;
    } t_lookup;

    // one batch of bytes for the emitter
    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [TOTAL_W-1:0] shift;
        logic [LEFT_W-1:0]  left;
    } t_job;

endpackage

### hdl/prefix_code_bit_packer.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// table-driven prefix code encoder packing code bits into bytes
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall, a word is taken when i_valid is high and
//   o_stall is low; i_mode selects load of a table entry, encode of a symbol
//   or flush of the leftover bits padded with zeros
// output channel: o_valid / i_stall, one byte per word, earliest code bit in
//   bit 7; o_last marks the final byte caused by one input word
// path: the first byte of an item passes the table read register, the batch
//   register and the output register before it shows on o_valid
// throughput: one input word per cycle while items give at most one byte and
//   the receiver does not stall; an item giving more bytes holds the single
//   byte-wide output port until its bytes are sent, at most 4 per item
// loads and items that give no byte pass on without waiting for the emitter;
//   a load may be followed at once by an encode of the same symbol
// reset clears the pending bits and all control; the code table is not
//   cleared and an entry must be loaded before it is encoded
// when the receiver stalls, the output byte holds, one batch waits in the
//   emitter and one more in the merge stage, then o_stall rises
// ----------------------------------------------------------------------------
module prefix_code_bit_packer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pcbp_pkg::MODE_W-1:0]       i_mode,
    input  logic [pcbp_pkg::SYM_W-1:0]        i_symbol,
    input  logic [pcbp_pkg::VALUE_BITS-1:0]   i_code_value,
    input  logic [pcbp_pkg::LEN_W-1:0]        i_code_length,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pcbp_pkg::BYTE_BITS-1:0]    o_out_byte,
    output logic                              o_last
);
    import pcbp_pkg::*;

    t_lookup w_lookup;
    t_job    w_job;
    logic    w_accept;
    logic    w_advance;
    logic    w_job_valid;
    logic    w_job_ready;

    // merge stage occupied and unable to hand on its word
    assign o_stall  = w_lookup.valid && !w_advance;
    assign w_accept = i_valid && !o_stall;

    // table write on load, table read on every accepted word
    pcbp_code_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_mode        (i_mode),
        .i_symbol      (i_symbol),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .i_advance     (w_advance),
        .o_lookup      (w_lookup)
    );

    // pending bits live here; whole bytes go on as one batch
    pcbp_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lookup    (w_lookup),
        .o_advance   (w_advance),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_ready (w_job_ready)
    );

    // batch serializer and output register
    pcbp_byte_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_ready (w_job_ready),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

### hdl/pcbp_code_table.sv
// ----------------------------------------------------------------------------
// pcbp_code_table
// code table memory with one write and one registered read port
// ----------------------------------------------------------------------------
module pcbp_code_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [pcbp_pkg::MODE_W-1:0]   i_mode,
    input  logic [pcbp_pkg::SYM_W-1:0]    i_symbol,
    input  logic [pcbp_pkg::VALUE_BITS-1:0] i_code_value,
    input  logic [pcbp_pkg::LEN_W-1:0]    i_code_length,
    input  logic                          i_advance,
    output pcbp_pkg::t_lookup             o_lookup
);
    import pcbp_pkg::*;

    localparam int MASK_W = VALUE_BITS + 1;

    t_entry              r_mem [SYMBOL_COUNT];
    t_entry              r_rd;
    logic                r_valid;
    logic [MODE_W-1:0]   r_mode;
    logic                r_hit;

    logic                w_hit;
    logic [IDX_W-1:0]    w_idx;
    logic [LEN_W-1:0]    w_len;
    logic [MASK_W-1:0]   w_mask;
    t_entry              w_wr;

    assign w_hit  = ({1'b0, i_symbol} < (SYM_W+1)'(SYMBOL_COUNT));
    assign w_idx  = i_symbol[IDX_W-1:0];
    // saturate the length, drop stray bits above it
    assign w_len  = (i_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : i_code_length;
    assign w_mask = (MASK_W'(1) << w_len) - MASK_W'(1);
    assign w_wr   = '{len: w_len, value: i_code_value & w_mask[VALUE_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_mode == MODE_LOAD) && w_hit) begin
            r_mem[w_idx] <= w_wr;
        end
        if (i_accept) begin
            r_rd <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mode <= i_mode;
            r_hit  <= w_hit;
        end
    end

    assign o_lookup = '{valid: r_valid, mode: r_mode, hit: r_hit, entry: r_rd};

endmodule

### hdl/pcbp_accum.sv
// ----------------------------------------------------------------------------
// pcbp_accum
// merges the looked-up code with the pending bits and forms byte batches
// ----------------------------------------------------------------------------
module pcbp_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcbp_pkg::t_lookup i_lookup,
    output logic              o_advance,
    output logic              o_job_valid,
    output pcbp_pkg::t_job    o_job,
    input  logic              i_job_ready
);
    import pcbp_pkg::*;

    logic [PEND_W-1:0]  r_pend;
    logic [CNT_W-1:0]   r_cnt;
    logic [PEND_W-1:0]  n_pend;
    logic [CNT_W-1:0]   n_cnt;

    logic [ACC_W-1:0]   w_acc;
    logic [TOTAL_W-1:0] w_total;
    logic [LEFT_W-1:0]  w_nbytes;
    logic [CNT_W-1:0]   w_rem;
    logic [BYTE_BITS-1:0] w_rmask;
    logic [3:0]         w_fsh;
    logic [BYTE_BITS-1:0] w_fbyte;
    logic               w_act;
    logic               w_need;

    assign w_acc    = ({{VALUE_BITS{1'b0}}, r_pend} << i_lookup.entry.len)
                    | ACC_W'(i_lookup.entry.value);
    assign w_total  = TOTAL_W'(r_cnt) + TOTAL_W'(i_lookup.entry.len);
    assign w_nbytes = LEFT_W'(w_total >> 3);
    assign w_rem    = w_total[CNT_W-1:0];
    assign w_rmask  = (BYTE_BITS'(1) << w_rem) - BYTE_BITS'(1);
    // flush pads the leftover bits up to the byte boundary
    assign w_fsh    = 4'(BYTE_BITS) - {1'b0, r_cnt};
    assign w_fbyte  = BYTE_BITS'({1'b0, r_pend} << w_fsh);

    always_comb begin
        w_act  = 1'b0;
        w_need = 1'b0;
        n_pend = r_pend;
        n_cnt  = r_cnt;
        o_job  = '{acc: w_acc, shift: w_total - TOTAL_W'(BYTE_BITS), left: w_nbytes};
        case (i_lookup.mode)
            MODE_ENCODE: begin
                if (i_lookup.hit && (i_lookup.entry.len != '0)) begin
                    w_act  = 1'b1;
                    w_need = (w_nbytes != '0);
                    n_pend = w_acc[PEND_W-1:0] & w_rmask[PEND_W-1:0];
                    n_cnt  = w_rem;
                end
            end
            MODE_FLUSH: begin
                if (r_cnt != '0) begin
                    w_act  = 1'b1;
                    w_need = 1'b1;
                    n_pend = '0;
                    n_cnt  = '0;
                    o_job  = '{acc: ACC_W'(w_fbyte), shift: '0, left: LEFT_W'(1)};
                end
            end
            default: begin
                w_act = 1'b0;
            end
        endcase
    end

    assign o_advance   = i_lookup.valid && (!w_need || i_job_ready);
    assign o_job_valid = i_lookup.valid && w_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else if (o_advance && w_act) begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### hdl/pcbp_byte_emit.sv
// ----------------------------------------------------------------------------
// pcbp_byte_emit
// holds one byte batch and sends it a word at a time into the output register
// ----------------------------------------------------------------------------
module pcbp_byte_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  pcbp_pkg::t_job                  i_job,
    output logic                            o_job_ready,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [pcbp_pkg::BYTE_BITS-1:0]  o_out_byte,
    output logic                            o_last
);
    import pcbp_pkg::*;

    logic                 r_job_valid;
    t_job                 r_job;
    logic                 r_out_valid;
    logic [BYTE_BITS-1:0] r_out_byte;
    logic                 r_out_last;

    logic [ACC_W-1:0]     w_shifted;
    logic                 w_fire;
    logic                 w_final;

    assign w_shifted   = r_job.acc >> r_job.shift;
    assign w_fire      = r_job_valid && (!r_out_valid || !i_stall);
    assign w_final     = (r_job.left == LEFT_W'(1));
    assign o_job_ready = !r_job_valid || (w_fire && w_final);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (i_job_valid && o_job_ready) begin
            r_job_valid <= 1'b1;
        end else if (w_fire && w_final) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid && o_job_ready) begin
            r_job <= i_job;
        end else if (w_fire) begin
            r_job.shift <= r_job.shift - TOTAL_W'(BYTE_BITS);
            r_job.left  <= r_job.left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_byte <= w_shifted[BYTE_BITS-1:0];
            r_out_last <= w_final;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

### hdl/pcbp_checker.sv
// ----------------------------------------------------------------------------
// pcbp_checker
// port-level checks of the prefix code bit packer, bound to the top level
// ----------------------------------------------------------------------------
module pcbp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [pcbp_pkg::BYTE_BITS-1:0]    o_out_byte,
    input logic                              o_last
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // reset empties the merge stage, so nothing holds the input back
    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // a stalled output word stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_byte) && $stable(o_last))
        else $error("output word changed under stall");

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (.*);
